@@ rtl/core/fqr_pkg.sv @@
// ----------------------------------------------------------------------------
// fqr_pkg
// Shared widths, defaults and command codes for the indexed-removal queue.
// ----------------------------------------------------------------------------
package fqr_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int POS_W     = 4;
    localparam int LEN_W     = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REM = 2'd2;

endpackage

@@ rtl/core/fqr_ram.sv @@
// ----------------------------------------------------------------------------
// fqr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/fifo_queue_with_remove_at_index.sv @@
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_at_index
// Bounded queue of signed 32-bit words with dequeue and removal by position.
// ----------------------------------------------------------------------------
// Each input transfer carries a command on s_tuser: enqueue appends the word
// from s_tdata at the tail, dequeue removes the head word, remove-at removes
// the word at a zero-based position from the head and closes the gap. Each
// command yields exactly one result transfer: the removed word, an ok flag
// and the queue length after the step.
// Words live in a ring buffer in one RAM with a registered read port.
// Enqueue and any failed command finish in S_IDLE, dequeue in S_CAP after the
// registered RAM read; remove at a nonzero position p also passes through S_SHIFT,
// where the entries ahead of the gap move one place toward the tail, one read
// and one write per cycle through the single read port; the head then advances.
// A new command is accepted once the previous one has left for the output
// register, so only one command is in progress at a time.
// Reset empties the queue; RAM contents are not cleared and only words below
// the fill count are used. When the receiver stalls, the held result stays on
// m_tdata/m_tuser; a following command still executes and waits for the
// output register, and s_tready stays low until that result is loaded.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_at_index #(
    parameter int DEPTH = fqr_pkg::DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fqr_pkg::S_TDATA_W-1:0]  s_tdata,   // in_data[31:0], position[35:32]
    input  logic [fqr_pkg::CMD_W-1:0]      s_tuser,   // command[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fqr_pkg::M_TDATA_W-1:0]  m_tdata,   // out_data[31:0], length[36:32]
    output logic                           m_tuser    // ok
);

    import fqr_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CAP   = 4'b0010,
        S_SHIFT = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     src_reg, src_next;
    logic [AW-1:0]     left_reg, left_next;
    logic [DATA_W-1:0] word_reg, word_next;
    logic [DATA_W-1:0] pend_data_reg, pend_data_next;
    logic              pend_ok_reg, pend_ok_next;
    logic [LEN_W-1:0]  pend_len_reg, pend_len_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic              m_ok_reg, m_ok_next;
    logic [LEN_W-1:0]  m_len_reg, m_len_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              fin;
    logic              fin_ok;
    logic [DATA_W-1:0] fin_data;
    logic              out_free;
    logic              rem_valid;
    logic [AW-1:0]     rem_off;
    logic [AW-1:0]     rem_addr;

    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] in_data;
    logic [POS_W-1:0]  position;

    assign cmd      = s_tuser;
    assign in_data  = s_tdata[DATA_W-1:0];
    assign position = s_tdata[DATA_W+POS_W-1:DATA_W];

    function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] a);
        return (a == LAST) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] dec_wrap(input logic [AW-1:0] a);
        return (a == '0) ? LAST : a - 1'b1;
    endfunction

    fqr_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign rem_valid = (cmd == CMD_DEQ) ? (count_reg != '0)
                                        : (CMPW'(position) < CMPW'(count_reg));
    assign rem_off  = (cmd == CMD_DEQ) ? '0 : AW'(position);
    assign rem_addr = add_wrap(head_reg, rem_off);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        src_next       = src_reg;
        left_next      = left_reg;
        word_next      = word_reg;
        pend_data_next = pend_data_reg;
        pend_ok_next   = pend_ok_reg;
        pend_len_next  = pend_len_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_ok_next      = m_ok_reg;
        m_len_next     = m_len_reg;
        ram_we         = 1'b0;
        ram_waddr      = add_wrap(head_reg, AW'(count_reg));
        ram_wdata      = in_data;
        ram_raddr      = head_reg;
        fin            = 1'b0;
        fin_ok         = 1'b0;
        fin_data       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    fin = 1'b1;
                    unique case (cmd) inside
                        CMD_ENQ: begin
                            if (count_reg < CW'(DEPTH)) begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                fin_ok     = 1'b1;
                            end
                        end
                        CMD_DEQ, CMD_REM: begin
                            if (rem_valid) begin
                                fin        = 1'b0;
                                ram_raddr  = rem_addr;
                                src_next   = rem_addr;
                                left_next  = rem_off;
                                state_next = S_CAP;
                            end
                        end
                        default: begin
                            fin_ok = 1'b0;
                        end
                    endcase
                end
            end
            S_CAP: begin
                word_next = ram_rdata;
                if (left_reg == '0) begin
                    fin        = 1'b1;
                    fin_ok     = 1'b1;
                    fin_data   = ram_rdata;
                    head_next  = inc_wrap(head_reg);
                    count_next = count_reg - 1'b1;
                end else begin
                    ram_raddr  = dec_wrap(src_reg);
                    src_next   = dec_wrap(src_reg);
                    left_next  = left_reg - 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = inc_wrap(src_reg);
                ram_wdata = ram_rdata;
                if (left_reg == '0) begin
                    fin        = 1'b1;
                    fin_ok     = 1'b1;
                    fin_data   = word_reg;
                    head_next  = inc_wrap(head_reg);
                    count_next = count_reg - 1'b1;
                end else begin
                    ram_raddr = dec_wrap(src_reg);
                    src_next  = dec_wrap(src_reg);
                    left_next = left_reg - 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_data_reg;
                    m_ok_next    = pend_ok_reg;
                    m_len_next   = pend_len_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_data_next  = fin_data;
                m_ok_next    = fin_ok;
                m_len_next   = LEN_W'(count_next);
                state_next   = S_IDLE;
            end else begin
                pend_data_next = fin_data;
                pend_ok_next   = fin_ok;
                pend_len_next  = LEN_W'(count_next);
                state_next     = S_OUT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
        src_reg       <= src_next;
        left_reg      <= left_next;
        word_reg      <= word_next;
        pend_data_reg <= pend_data_next;
        pend_ok_reg   <= pend_ok_next;
        pend_len_reg  <= pend_len_next;
        m_data_reg    <= m_data_next;
        m_ok_reg      <= m_ok_next;
        m_len_reg     <= m_len_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - DATA_W - LEN_W){1'b0}}, m_len_reg, m_data_reg};
    assign m_tuser  = m_ok_reg;

endmodule

@@ tb/tb_fifo_queue_with_remove_at_index.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_queue_with_remove_at_index
// Self-checking bench for the indexed-removal queue.
// ----------------------------------------------------------------------------
// Commands go in on the s_ stream and results come back on the m_ stream.
// Each accepted command updates a shadow queue of words that predicts the
// removed word, the ok flag and the length after the step; each result
// transfer is checked against the oldest prediction. Stimulus covers the
// corner cases by hand, a long receiver stall that backs up the input at the
// start of a burst that fills the queue, and phases of random traffic with
// fill, drain and balanced command mixes under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_fifo_queue_with_remove_at_index;
    import fqr_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int QDEPTH       = DEPTH_DEF;
    localparam int SETTLE_CYCLES = QDEPTH + 24;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [DATA_W-1:0] word;
        logic              ok;
        logic [LEN_W-1:0]  len;
    } queue_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;  // in_data[31:0], position[35:32]
    logic [CMD_W-1:0]      s_tuser  = '0;  // command[1:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;        // out_data[31:0], length[36:32]
    logic                  m_tuser;        // ok

    logic [DATA_W-1:0] held_words[$];
    queue_result_t     pending_results[$];
    int                errors         = 0;
    bit                tx_idle_on     = 1'b0;
    bit                rx_idle_on     = 1'b0;
    int                rx_wait        = 0;
    int                rx_hold_cycles = 0;

    always #2 aclk = ~aclk;

    fifo_queue_with_remove_at_index #(
        .DEPTH(QDEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic queue_result_t queue_apply(input logic [CMD_W-1:0]  cmd,
                                                  input logic [DATA_W-1:0] word,
                                                  input logic [POS_W-1:0]  pos);
        queue_result_t r;
        r = '0;
        case (cmd)
            CMD_ENQ: begin
                if (held_words.size() < QDEPTH) begin
                    held_words.push_back(word);
                    r.ok = 1'b1;
                end
            end
            CMD_DEQ: begin
                if (held_words.size() > 0) begin
                    r.word = held_words.pop_front();
                    r.ok   = 1'b1;
                end
            end
            CMD_REM: begin
                if (int'(pos) < held_words.size()) begin
                    r.word = held_words[pos];
                    held_words.delete(int'(pos));
                    r.ok   = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.len = LEN_W'(held_words.size());
        return r;
    endfunction

    always @(posedge aclk) begin
        queue_result_t exp_r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with none expected: m_tdata=%h m_tuser=%b",
                           m_tdata, m_tuser);
                    errors++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (m_tdata[31:0] !== exp_r.word) begin
                        $error("out_data expected %0d actual %0d",
                               $signed(exp_r.word), $signed(m_tdata[31:0]));
                        errors++;
                    end
                    if (m_tuser !== exp_r.ok) begin
                        $error("ok expected %0d actual %0d", exp_r.ok, m_tuser);
                        errors++;
                    end
                    if (m_tdata[36:32] !== exp_r.len) begin
                        $error("length expected %0d actual %0d", exp_r.len, m_tdata[36:32]);
                        errors++;
                    end
                end
                rx_wait = rx_idle_on ? $urandom_range(0, 14) : 0;
            end
            if (s_tvalid && s_tready) begin
                pending_results.push_back(queue_apply(s_tuser, s_tdata[31:0], s_tdata[35:32]));
            end
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end else if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_cmd(input logic [CMD_W-1:0]  cmd,
                            input logic [DATA_W-1:0] word,
                            input logic [POS_W-1:0]  pos);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({pos, word});
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_reset();
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic test_directed();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        // empty queue: every removal fails
        send_cmd(CMD_DEQ, 32'h0000_0000, 4'd0);
        send_cmd(CMD_REM, 32'h1234_5678, 4'd0);
        send_cmd(CMD_NOP, 32'hFFFF_FFFF, 4'd15);
        send_cmd(CMD_ENQ, 32'h8000_0000, 4'd15);
        send_cmd(CMD_ENQ, 32'h7FFF_FFFF, 4'd0);
        send_cmd(CMD_ENQ, 32'h0000_0000, 4'd5);
        send_cmd(CMD_ENQ, 32'hFFFF_FFFF, 4'd10);
        send_cmd(CMD_REM, 32'hA5A5_A5A5, 4'd4);
        send_cmd(CMD_REM, 32'h0000_0000, 4'd15);
        send_cmd(CMD_NOP, 32'h0000_0000, 4'd0);
        send_cmd(CMD_REM, 32'h0000_0000, 4'd3);
        send_cmd(CMD_REM, 32'h0000_0000, 4'd1);
        send_cmd(CMD_DEQ, 32'hFFFF_FFFF, 4'd15);
        send_cmd(CMD_DEQ, 32'h0000_0000, 4'd0);
        send_cmd(CMD_DEQ, 32'h0000_0000, 4'd0);
        wait_drained();
    endtask

    task automatic test_stall_fill();
        int n;
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        // hold the receiver at the start of a burst that fills and overflows the queue
        for (int i = 0; i < QDEPTH + 2; i++) begin
            send_cmd(CMD_ENQ, $urandom(), POS_W'($urandom_range(0, 15)));
        end
        send_cmd(CMD_REM, $urandom(), 4'd15);
        send_cmd(CMD_REM, $urandom(), 4'd0);
        send_cmd(CMD_ENQ, $urandom(), 4'd0);
        send_cmd(CMD_REM, $urandom(), 4'd14);
        send_cmd(CMD_REM, $urandom(), 4'd7);
        wait_drained();
        n = held_words.size();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (n) send_cmd(CMD_DEQ, $urandom(), POS_W'($urandom_range(0, 15)));
        wait_drained();
    endtask

    task automatic test_random();
        int bias;
        int enq_pct;
        int r;
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] word;
        logic [POS_W-1:0]  pos;
        for (int phase = 0; phase < 16; phase++) begin
            bias       = $urandom_range(0, 2);
            enq_pct    = (bias == 0) ? 70 : (bias == 1) ? 25 : 45;
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < 100; i++) begin
                r = $urandom_range(0, 99);
                if (r < enq_pct) begin
                    cmd = CMD_ENQ;
                end else begin
                    r = $urandom_range(0, 99);
                    cmd = (r < 4) ? CMD_NOP : (r < 40) ? CMD_DEQ : CMD_REM;
                end
                case ($urandom_range(0, 7))
                    0:       word = 32'h8000_0000;
                    1:       word = 32'h7FFF_FFFF;
                    default: word = $urandom();
                endcase
                if ($urandom_range(0, 4) == 0 || held_words.size() == 0) begin
                    pos = POS_W'($urandom_range(0, 15));
                end else begin
                    pos = POS_W'($urandom_range(0, held_words.size() - 1));
                end
                send_cmd(cmd, word, pos);
            end
        end
        wait_drained();
    endtask

    initial begin
        test_reset();
        test_directed();
        test_stall_fill();
        test_random();
        wait_drained();
        if (errors == 0 && pending_results.size() == 0) begin
            $display("fifo_queue_with_remove_at_index verification clean");
        end else begin
            $display("fifo_queue_with_remove_at_index verification failed");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("fifo_queue_with_remove_at_index verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/fqr_pkg.sv
rtl/core/fqr_ram.sv
rtl/core/fifo_queue_with_remove_at_index.sv
tb/tb_fifo_queue_with_remove_at_index.sv
